// ===== hw/rtl/otq_pkg.sv =====
// Shared constants and types for the ordered timer queue.
`timescale 1ns / 1ps
`default_nettype none

package otq_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TIME_W  = 64;
  localparam int KEY_W   = 2 * TIME_W;   // {due, sequence}

  typedef enum logic [2:0] {
    OP_START        = 3'd0,
    OP_STOP         = 3'd1,
    OP_AGAIN        = 3'd2,
    OP_SET_REPEAT   = 3'd3,
    OP_GET_REPEAT   = 3'd4,
    OP_NEXT_TIMEOUT = 3'd5
  } op_t;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_NOT_STARTED = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/otq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module otq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_timer_queue.sv =====
// Ordered timer queue: timer slots, with a timeout search for the soonest due slot.
//
// The block takes one operation at a time. Start, stop, again, set repeat and
// get repeat pass through an execute state and a done state; next timeout
// adds a search state that reads the due/sequence RAM one slot per cycle and
// a final state. A finished result sits in the output register, and a new
// operation is taken while it waits to be collected. Due time and sequence live
// in one RAM, repeat periods in a second; per-slot active, started and group
// flags and a written flag for the repeat RAM are flip-flops cleared by reset,
// so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ordered_timer_queue
  import otq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [3:0]  slot,
  input  wire logic        timer_kind,
  input  wire logic [63:0] due_time,
  input  wire logic [63:0] period,
  input  wire logic [63:0] now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic      [63:0] delay,
  output logic             found,
  output logic      [3:0]  soonest_slot,
  output logic      [63:0] period_value
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINAL,
    ST_DONE
  } state_t;

  state_t state;

  // latched operation
  logic [2:0]        op_q;
  logic [3:0]        slot_q;
  logic              kind_q;
  logic [TIME_W-1:0] due_q;
  logic [TIME_W-1:0] period_q;
  logic [TIME_W-1:0] now_q;

  // per-slot flags
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] started;
  logic [SLOTS-1:0] group;
  logic [SLOTS-1:0] rep_written;

  logic [TIME_W-1:0] seq_cnt;

  // search
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  logic             have;
  logic [KEY_W-1:0] best_key;
  logic [IDX_W-1:0] best_idx;

  // pending result
  logic              res_status;
  logic [TIME_W-1:0] res_delay;
  logic              res_found;
  logic [3:0]        res_soonest;
  logic [TIME_W-1:0] res_pval;

  // RAM ports
  logic              ds_we;
  logic [KEY_W-1:0]  ds_wdata;
  logic [KEY_W-1:0]  ds_rdata;
  logic              rp_we;
  logic [TIME_W-1:0] rp_wdata;
  logic [TIME_W-1:0] rp_rdata;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;

  logic              slot_ok;
  logic [IDX_W-1:0]  sidx;
  logic [TIME_W-1:0] rep_val;
  logic [TIME_W:0]   again_sum;
  logic [TIME_W-1:0] again_when;
  logic              arm_start;
  logic              arm_again;
  logic              scan_live;
  logic              cand_hit;

  assign in_ready = (state == ST_IDLE);

  assign sidx    = IDX_W'(slot_q);
  assign slot_ok = (32'(slot_q) < SLOTS);
  assign waddr   = sidx;

  assign scan_live = (state == ST_SCAN) && (32'(cnt) < SLOTS);
  assign raddr     = (state == ST_SCAN) ? (scan_live ? cnt[IDX_W-1:0] : '0)
                                        : IDX_W'(slot);

  // never-written repeat entries read as zero
  assign rep_val    = rep_written[sidx] ? rp_rdata : '0;
  assign again_sum  = {1'b0, now_q} + {1'b0, rep_val};
  assign again_when = again_sum[TIME_W] ? '1 : again_sum[TIME_W-1:0];

  always_comb begin
    arm_start = 1'b0;
    arm_again = 1'b0;
    if (state == ST_EXEC && slot_ok) begin
      arm_start = (op_q == OP_START);
      arm_again = (op_q == OP_AGAIN) && started[sidx] && (rep_val != '0);
    end
  end

  assign ds_we    = arm_start || arm_again;
  assign ds_wdata = {(arm_start ? due_q : again_when), seq_cnt};
  assign rp_we    = (state == ST_EXEC) && slot_ok &&
                    ((op_q == OP_START) || (op_q == OP_SET_REPEAT));
  assign rp_wdata = period_q;

  assign cand_hit = rd_live && active[rd_idx] && !group[rd_idx] &&
                    (!have || (ds_rdata < best_key));

  otq_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_due_seq_ram (
    .clk   (clk),
    .we    (ds_we),
    .waddr (waddr),
    .wdata (ds_wdata),
    .raddr (raddr),
    .rdata (ds_rdata)
  );

  otq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_repeat_ram (
    .clk   (clk),
    .we    (rp_we),
    .waddr (waddr),
    .wdata (rp_wdata),
    .raddr (raddr),
    .rdata (rp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= '0;
      started     <= '0;
      group       <= '0;
      rep_written <= '0;
      seq_cnt     <= '0;
      cnt         <= '0;
      rd_live     <= 1'b0;
      have        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_idx  <= raddr;
      rd_live <= scan_live;

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (ds_we) begin
        seq_cnt        <= seq_cnt + 1'b1;
        active[sidx]   <= 1'b1;
        started[sidx]  <= 1'b1;
      end
      if (arm_start) begin
        group[sidx] <= kind_q;
      end
      if (rp_we) begin
        rep_written[sidx] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q     <= operation;
            slot_q   <= slot;
            kind_q   <= timer_kind;
            due_q    <= due_time;
            period_q <= period;
            now_q    <= now;
            state    <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res_status  <= STATUS_OK;
          res_delay   <= '0;
          res_found   <= 1'b0;
          res_soonest <= '0;
          res_pval    <= '0;
          state       <= ST_DONE;
          if (op_q == OP_NEXT_TIMEOUT) begin
            cnt   <= '0;
            have  <= 1'b0;
            state <= ST_SCAN;
          end else if (slot_ok) begin
            unique case (op_q)
              OP_STOP:       active[sidx] <= 1'b0;
              OP_AGAIN:      if (!started[sidx]) res_status <= STATUS_NOT_STARTED;
              OP_GET_REPEAT: res_pval <= rep_val;
              default:       ;
            endcase
          end
        end

        ST_SCAN: begin
          // read data arriving now belongs to the slot addressed last cycle
          if (cand_hit) begin
            have     <= 1'b1;
            best_key <= ds_rdata;
            best_idx <= rd_idx;
          end
          if (32'(cnt) == SLOTS) begin
            state <= ST_FINAL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_FINAL: begin
          if (have) begin
            res_found   <= 1'b1;
            res_soonest <= 4'(best_idx);
            res_delay   <= (best_key[KEY_W-1:TIME_W] > now_q)
                           ? best_key[KEY_W-1:TIME_W] - now_q : '0;
          end
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            delay        <= res_delay;
            found        <= res_found;
            soonest_slot <= res_soonest;
            period_value <= res_pval;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while an operation is in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> 32'(cnt) <= SLOTS)
    else $error("search counter ran past the last slot");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> delay == '0 && soonest_slot == '0)
    else $error("delay or slot reported without a timer found");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !found && delay == '0 && period_value == '0)
    else $error("error status carries other result fields");
`endif

endmodule

`default_nettype wire
